### design/nsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence framer package
// Shared widths, character codes, verdict codes and item types for the framer.
// ----------------------------------------------------------------------------
package nsf_pkg;

   // Widths of the stream fields.
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 11;

   // Longest sentence the hardware ever allows, and the cap on the limit.
   localparam int MAX_SENTENCE = 1024;
   localparam int LIMIT_CAP_INT = (MAX_SENTENCE < 2046) ? MAX_SENTENCE : 2046;
   localparam int LIMIT_RST_INT = (LIMIT_CAP_INT < 1024) ? LIMIT_CAP_INT : 1024;
   localparam logic [LEN_W-1:0] LIMIT_CAP   = LIMIT_CAP_INT[LEN_W-1:0];
   localparam logic [LEN_W-1:0] LIMIT_RESET = LIMIT_RST_INT[LEN_W-1:0];

   // Queue between the classifier and the framing engine.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Character codes.
   localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

   // Sentence verdicts.
   typedef enum logic [2:0] {
      VERDICT_NONE     = 3'd0,
      VERDICT_OK       = 3'd1,
      VERDICT_MISMATCH = 3'd2,
      VERDICT_TOO_LONG = 3'd3,
      VERDICT_NO_STAR  = 3'd4
   } verdict_type;

   // Hex digit decode of one character.
   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   // One classified request as it travels through the queue.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              is_dollar;
      logic              is_star;
      logic              is_cr;
      logic              is_lf;
      hex_type           hex;
   } item_type;

   // One result as it is held in the output register.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              in_frame;
      logic              frame_end;
      verdict_type       verdict;
      logic [LEN_W-1:0]  frame_length;
   } result_type;

   // Decode one character as a hex digit.
   function automatic hex_type hex_decode(input logic [BYTE_W-1:0] c);
      hex_type h;
      h.ok  = 1'b0;
      h.val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.ok  = 1'b1;
         h.val = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         h.ok  = 1'b1;
         h.val = c[3:0] + 4'd9;
      end
      return h;
   endfunction

endpackage

### design/nmea_sentence_framer.sv
`timescale 1ns / 1ps
// Path: an accepted request is written into the queue, then into the engine's
//   output register, where its result is offered until it is taken.
// Throughput: one request per cycle unless rsp_tready stalls; the engine's output register is the
//   only per-item step, and the 4-entry queue absorbs short output stalls.
// Reset: synchronous, active high; clears framing and the queue, and sets the
//   length limit to 1024 bytes.
// ----------------------------------------------------------------------------
// NMEA sentence framer
// Frames NMEA sentences in a byte stream and checks their XOR checksum.
// ----------------------------------------------------------------------------
module nmea_sentence_framer (
   input  logic        clock,
   input  logic        reset,
   // Configuration: max_length.
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,
   // Request channel. tdata: byte_in[7:0].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: byte_out[7:0], verdict[10:8], frame_length[21:11], zero[23:22].
   output logic [23:0] rsp_tdata,
   // tuser: in_frame.
   output logic        rsp_tuser,
   // tlast: frame_end.
   output logic        rsp_tlast
);

   logic                queue_full;
   logic                queue_not_empty;
   logic                push;
   logic                pop;
   nsf_pkg::item_type   push_item;
   nsf_pkg::item_type   pop_item;
   nsf_pkg::result_type result;

   // Classifier.
   nsf_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // Queue between classifier and engine.
   nsf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_item  (pop_item)
   );

   // Framing engine.
   nsf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .queue_not_empty (queue_not_empty),
      .queue_item      (pop_item),
      .pop             (pop),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_result      (result)
   );

   // Pack the result onto the stream.
   assign rsp_tdata = {2'b00, result.frame_length, result.verdict, result.data};
   assign rsp_tuser = result.in_frame;
   assign rsp_tlast = result.frame_end;

endmodule

### design/nsf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA framer classifier
// Accepts request bytes and tags them with their character class and hex value.
// ----------------------------------------------------------------------------
module nsf_front (
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [nsf_pkg::BYTE_W-1:0] req_tdata,
   input  logic                      queue_full,
   output logic                      push,
   output nsf_pkg::item_type         push_item
);

   // A request is taken whenever the queue has room.
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // Classify the character for the framing engine.
   always_comb begin
      push_item.data      = req_tdata;
      push_item.is_dollar = (req_tdata == nsf_pkg::CH_DOLLAR);
      push_item.is_star   = (req_tdata == nsf_pkg::CH_STAR);
      push_item.is_cr     = (req_tdata == nsf_pkg::CH_CR);
      push_item.is_lf     = (req_tdata == nsf_pkg::CH_LF);
      push_item.hex       = nsf_pkg::hex_decode(req_tdata);
   end

endmodule

### design/nsf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA framer item queue
// Short first-in first-out buffer between the classifier and the engine.
// ----------------------------------------------------------------------------
module nsf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  nsf_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output nsf_pkg::item_type pop_item
);

   nsf_pkg::item_type                entry_ff [nsf_pkg::QUEUE_DEPTH];
   logic [nsf_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [nsf_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [nsf_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign full      = (count_ff == nsf_pkg::QCNT_W'(nsf_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= nsf_pkg::QCNT_W'(nsf_pkg::QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not drop after a pop");
`endif

endmodule

### design/nsf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA framer engine
// Tracks framing, checksum, length and trailing characters, and issues results.
// ----------------------------------------------------------------------------
module nsf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [nsf_pkg::LEN_W-1:0]  csr_wr_data,
   input  logic                       queue_not_empty,
   input  nsf_pkg::item_type          queue_item,
   output logic                       pop,
   output logic                       out_valid,
   input  logic                       out_ready,
   output nsf_pkg::result_type        out_result
);

   // Length limit in force, already clamped.
   logic [nsf_pkg::LEN_W-1:0]  limit_ff, limit_in;
   // Sentence state.
   logic                       framing_ff, framing_in;
   logic [nsf_pkg::BYTE_W-1:0] xor_sum_ff, xor_sum_in;
   logic                       star_seen_ff, star_seen_in;
   logic [nsf_pkg::LEN_W-1:0]  count_ff, count_in;
   // Last three sentence bytes: newest as CR flag and hex digit, older two as hex digits.
   logic                       prev_cr_ff, prev_cr_in;
   nsf_pkg::hex_type           hex0_ff, hex0_in;
   nsf_pkg::hex_type           hex1_ff, hex1_in;
   nsf_pkg::hex_type           hex2_ff, hex2_in;
   // Output register.
   logic                       out_valid_ff, out_valid_in;
   nsf_pkg::result_type        result_ff, result_in;

   logic [nsf_pkg::LEN_W-1:0]  limit_p1;
   logic [nsf_pkg::BYTE_W-1:0] given;

   assign pop        = queue_not_empty && (!out_valid_ff || out_ready);
   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;
   assign limit_p1   = limit_ff + 1'b1;

   // Clamp the limit when it is written.
   always_comb begin
      limit_in = limit_ff;
      if (csr_wr_en) begin
         limit_in = (csr_wr_data > nsf_pkg::LIMIT_CAP) ? nsf_pkg::LIMIT_CAP : csr_wr_data;
      end
   end

   // Checksum field: the two bytes before CR, cut short at a non-hex byte.
   always_comb begin
      if (!hex2_ff.ok) begin
         given = '0;
      end else if (!hex1_ff.ok) begin
         given = {4'd0, hex2_ff.val};
      end else begin
         given = {hex2_ff.val, hex1_ff.val};
      end
   end

   // Sentence state update and result for the item at the queue head.
   always_comb begin
      framing_in   = framing_ff;
      xor_sum_in   = xor_sum_ff;
      star_seen_in = star_seen_ff;
      count_in     = count_ff;
      prev_cr_in   = prev_cr_ff;
      hex0_in      = hex0_ff;
      hex1_in      = hex1_ff;
      hex2_in      = hex2_ff;

      result_in.data         = queue_item.data;
      result_in.in_frame     = 1'b0;
      result_in.frame_end    = 1'b0;
      result_in.verdict      = nsf_pkg::VERDICT_NONE;
      result_in.frame_length = '0;

      if (queue_item.is_dollar) begin
         // A dollar always starts a fresh sentence.
         framing_in   = 1'b1;
         xor_sum_in   = '0;
         star_seen_in = 1'b0;
         count_in     = nsf_pkg::LEN_W'(1);
         prev_cr_in   = 1'b0;
         hex0_in      = queue_item.hex;
         hex1_in      = '0;
         hex2_in      = '0;
         result_in.in_frame     = 1'b1;
         result_in.frame_length = nsf_pkg::LEN_W'(1);
      end else if (framing_ff) begin
         count_in = (count_ff < limit_p1) ? count_ff + 1'b1 : limit_p1;
         if (!star_seen_ff) begin
            if (queue_item.is_star) begin
               star_seen_in = 1'b1;
            end else begin
               xor_sum_in = xor_sum_ff ^ queue_item.data;
            end
         end
         result_in.in_frame     = 1'b1;
         result_in.frame_length = count_in;
         // CR then LF closes the sentence.
         if (queue_item.is_lf && prev_cr_ff) begin
            if (count_in > limit_ff) begin
               result_in.verdict = nsf_pkg::VERDICT_TOO_LONG;
            end else if (!star_seen_in) begin
               result_in.verdict = nsf_pkg::VERDICT_NO_STAR;
            end else if (given == xor_sum_in) begin
               result_in.verdict = nsf_pkg::VERDICT_OK;
            end else begin
               result_in.verdict = nsf_pkg::VERDICT_MISMATCH;
            end
            result_in.frame_end = 1'b1;
            framing_in          = 1'b0;
         end
         prev_cr_in = queue_item.is_cr;
         hex0_in    = queue_item.hex;
         hex1_in    = hex0_ff;
         hex2_in    = hex1_ff;
      end
   end

   // Output register holds its result until taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= nsf_pkg::LIMIT_RESET;
         framing_ff   <= 1'b0;
         xor_sum_ff   <= '0;
         star_seen_ff <= 1'b0;
         count_ff     <= '0;
         prev_cr_ff   <= 1'b0;
         hex0_ff      <= '0;
         hex1_ff      <= '0;
         hex2_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         out_valid_ff <= out_valid_in;
         if (pop) begin
            framing_ff   <= framing_in;
            xor_sum_ff   <= xor_sum_in;
            star_seen_ff <= star_seen_in;
            count_ff     <= count_in;
            prev_cr_ff   <= prev_cr_in;
            hex0_ff      <= hex0_in;
            hex1_ff      <= hex1_in;
            hex2_ff      <= hex2_in;
         end
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_in;
      end
   end

`ifndef SYNTH
   a_end_has_verdict: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.frame_end) |->
         (result_ff.in_frame && result_ff.verdict != nsf_pkg::VERDICT_NONE))
      else $error("sentence end without a verdict");

   a_outside_quiet: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !result_ff.in_frame) |->
         (result_ff.frame_length == '0 && !result_ff.frame_end))
      else $error("byte outside a sentence carries sentence data");
`endif

endmodule
